@@ src/tmws_pkg.sv @@
// ----------------------------------------------------------------------------
// tmws_pkg
// Shared constants, codes, types and helpers for the tagged mixed-width stack.
// ----------------------------------------------------------------------------
`default_nettype none

package tmws_pkg;

    // Default sizes of the byte store and of the entry (tag) store.
    localparam int STORE_BYTES_DEF = 1024;
    localparam int MAX_ENTRIES_DEF = 1024;

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Width codes of an entry.
    localparam logic [1:0] WC_BYTE  = 2'd0;
    localparam logic [1:0] WC_WORD  = 2'd1;
    localparam logic [1:0] WC_DWORD = 2'd2;
    localparam logic [1:0] WC_BAD   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;       // Capture the accepted request.
        logic       push_wr;    // Write one byte of the pushed value.
        logic       pop_setup;  // Latch tag, byte count and base address of the pop.
        logic       pop_rd;     // Issue one byte read of the popped entry.
        logic       pop_commit; // Drop the popped entry from the stack.
        logic       out_load;   // Load the result register.
        logic [1:0] out_status; // Status to place in the result.
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic push_ok;     // The incoming push fits.
        logic stack_empty; // No entry is held.
        logic last;        // Current byte is the last one of the entry.
        logic pop_bad;     // Top entry claims more bytes than are in use.
    } stat_t;

    // Number of bytes taken by an entry of the given width code.
    function automatic logic [2:0] bytes_of(input logic [1:0] code);
        logic [2:0] n;
        case (code)
            WC_BYTE: n = 3'd1;
            WC_WORD: n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ src/tmws_datapath.sv @@
// ----------------------------------------------------------------------------
// tmws_datapath
// Byte store, tag store, stack pointers, value assembly and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmws_datapath #(
    parameter int STORE_BYTES = tmws_pkg::STORE_BYTES_DEF,
    parameter int MAX_ENTRIES = tmws_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_opcode,
    input  wire logic [1:0]     s_width_code,
    input  wire logic [31:0]    s_push_value,
    input  wire tmws_pkg::cmd_t cmd,
    output tmws_pkg::stat_t     stat,
    output logic [31:0]         m_pop_value,
    output logic [1:0]          m_pop_width,
    output logic [1:0]          m_status
);

    localparam int AW  = $clog2(STORE_BYTES);
    localparam int CW  = $clog2(STORE_BYTES + 1);
    localparam int CW1 = CW + 1;
    localparam int TAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW  = $clog2(MAX_ENTRIES + 1);

    localparam logic [CW1-1:0] STORE_LIM = CW1'(STORE_BYTES);
    localparam logic [EW-1:0]  ENTRY_LIM = EW'(MAX_ENTRIES);

    // Storage.
    logic [7:0] byte_mem [0:STORE_BYTES-1];
    logic [1:0] tag_mem  [0:MAX_ENTRIES-1];

    // Stack pointers.
    logic [CW-1:0] byte_top_reg;
    logic [EW-1:0] entry_count_reg;

    // Captured request and per-item working registers.
    logic          op_reg;
    logic [1:0]    wc_reg;
    logic [31:0]   val_reg;
    logic [2:0]    n_reg;
    logic [1:0]    idx_reg;
    logic [AW-1:0] base_reg;
    logic [1:0]    tag_reg;
    logic [31:0]   acc_reg;
    logic [7:0]    rd_reg;
    logic [1:0]    lane_reg;
    logic          pend_reg;
    logic [1:0]    tag_q_reg;

    logic [2:0]     n_in;
    logic [CW1-1:0] push_end;
    logic [EW-1:0]  entry_dec;
    logic [1:0]     tag_eff;
    logic [2:0]     n_tag;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  raddr;
    logic [7:0]     wbyte;
    logic [31:0]    val_shift;
    logic           push_last;

    // Checks on the incoming request and on the top entry.
    assign n_in      = tmws_pkg::bytes_of(s_width_code);
    assign push_end  = {1'b0, byte_top_reg} + CW1'(n_in);
    assign entry_dec = entry_count_reg - EW'(1);
    assign tag_eff   = (tag_q_reg == tmws_pkg::WC_BAD) ? tmws_pkg::WC_DWORD : tag_q_reg;
    assign n_tag     = tmws_pkg::bytes_of(tag_eff);

    assign stat.push_ok     = (s_width_code != tmws_pkg::WC_BAD) &&
                              (entry_count_reg < ENTRY_LIM) &&
                              (push_end <= STORE_LIM);
    assign stat.stack_empty = (entry_count_reg == '0);
    assign stat.last        = (idx_reg == 2'(n_reg - 3'd1));
    assign stat.pop_bad     = (CW'(n_tag) > byte_top_reg);

    // Byte addressing for push writes and pop reads.
    assign waddr     = byte_top_reg[AW-1:0] + AW'(idx_reg);
    assign raddr     = base_reg + AW'(idx_reg);
    assign val_shift = val_reg >> {idx_reg, 3'b000};
    assign wbyte     = val_shift[7:0];
    assign push_last = cmd.push_wr && stat.last;

    // Byte store: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            byte_mem[waddr] <= wbyte;
        end
        rd_reg <= byte_mem[raddr];
    end

    // Tag store: tag written on the last byte of a push, top tag read each cycle.
    always_ff @(posedge aclk) begin
        if (push_last) begin
            tag_mem[entry_count_reg[TAW-1:0]] <= wc_reg;
        end
        tag_q_reg <= tag_mem[entry_dec[TAW-1:0]];
    end

    // Stack pointers and the read-pending flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_top_reg    <= '0;
            entry_count_reg <= '0;
            pend_reg        <= 1'b0;
        end else begin
            pend_reg <= cmd.pop_rd;
            if (push_last) begin
                byte_top_reg    <= byte_top_reg + CW'(n_reg);
                entry_count_reg <= entry_count_reg + EW'(1);
            end else if (cmd.pop_commit) begin
                byte_top_reg    <= byte_top_reg - CW'(n_reg);
                entry_count_reg <= entry_dec;
            end
        end
    end

    // Working registers of the current request.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_opcode;
            wc_reg  <= s_width_code;
            val_reg <= s_push_value;
            n_reg   <= n_in;
            idx_reg <= 2'd0;
            acc_reg <= '0;
            tag_reg <= tmws_pkg::WC_BYTE;
        end else if (cmd.pop_setup) begin
            n_reg    <= n_tag;
            idx_reg  <= 2'd0;
            tag_reg  <= tag_eff;
            base_reg <= AW'(byte_top_reg - CW'(n_tag));
        end else if (cmd.push_wr || cmd.pop_rd) begin
            idx_reg <= idx_reg + 2'd1;
        end
        if (cmd.pop_rd) begin
            lane_reg <= idx_reg;
        end
        // Read data lands in rd_reg in the cycle after its address; place it in its lane.
        if (pend_reg) begin
            acc_reg[{lane_reg, 3'b000} +: 8] <= rd_reg;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status <= cmd.out_status;
            if (cmd.out_status == tmws_pkg::STAT_OK && op_reg == tmws_pkg::OP_POP) begin
                m_pop_value <= acc_reg;
                m_pop_width <= tag_reg;
            end else begin
                m_pop_value <= '0;
                m_pop_width <= tmws_pkg::WC_BYTE;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/tmws_ctrl.sv @@
// ----------------------------------------------------------------------------
// tmws_ctrl
// Request sequencer: steps one push or pop through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tmws_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            s_opcode,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire tmws_pkg::stat_t stat,
    output tmws_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_WR,
        S_POP_TAG,
        S_POP_CHK,
        S_POP_RD,
        S_POP_LAST,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       m_valid_reg, m_valid_next;

    logic accept;
    logic out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd            = '0;
        cmd.out_status = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (s_opcode == tmws_pkg::OP_POP) begin
                        if (stat.stack_empty) begin
                            status_next = tmws_pkg::STAT_UNDERFLOW;
                            state_next  = S_FINISH;
                        end else begin
                            status_next = tmws_pkg::STAT_OK;
                            state_next  = S_POP_TAG;
                        end
                    end else if (stat.push_ok) begin
                        status_next = tmws_pkg::STAT_OK;
                        state_next  = S_PUSH_WR;
                    end else begin
                        status_next = tmws_pkg::STAT_OVERFLOW;
                        state_next  = S_FINISH;
                    end
                end
            end
            S_PUSH_WR: begin
                cmd.push_wr = 1'b1;
                if (stat.last) begin
                    state_next = S_FINISH;
                end
            end
            S_POP_TAG: begin
                state_next = S_POP_CHK;
            end
            S_POP_CHK: begin
                if (stat.pop_bad) begin
                    status_next = tmws_pkg::STAT_UNDERFLOW;
                    state_next  = S_FINISH;
                end else begin
                    cmd.pop_setup = 1'b1;
                    state_next    = S_POP_RD;
                end
            end
            S_POP_RD: begin
                cmd.pop_rd = 1'b1;
                if (stat.last) begin
                    state_next = S_POP_LAST;
                end
            end
            S_POP_LAST: begin
                cmd.pop_commit = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            status_reg  <= tmws_pkg::STAT_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ src/tagged_mixed_width_stack.sv @@
// ----------------------------------------------------------------------------
// tagged_mixed_width_stack
// Byte-addressed stack of 1, 2 or 4 byte entries with a width tag per entry.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake           Payload
//   s_        in          s_valid / s_ready   s_opcode, s_width_code, s_push_value
//   m_        out         m_valid / m_ready   m_pop_value, m_pop_width, m_status
//
// One request is in flight at a time and moves one byte per cycle through
// the byte store. A push writes its n bytes (n = 1, 2 or 4), then loads the
// result; a rejected push or an empty pop goes straight to the result load;
// a pop runs tag read, check, n byte reads, final byte landing, result load.
// Reset clears the stack pointers and control; the stores need no clearing.
// A result waiting on m_ready does not block the next request from being
// accepted; that request's result is loaded once the output register frees.
//
`default_nettype none

module tagged_mixed_width_stack #(
    parameter int STORE_BYTES = tmws_pkg::STORE_BYTES_DEF,
    parameter int MAX_ENTRIES = tmws_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [1:0]  s_width_code,
    input  wire logic [31:0] s_push_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_pop_value,
    output logic [1:0]       m_pop_width,
    output logic [1:0]       m_status
);

    tmws_pkg::cmd_t  cmd;
    tmws_pkg::stat_t stat;

    // Sequencer.
    tmws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Stores, pointers and result register.
    tmws_datapath #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_opcode     (s_opcode),
        .s_width_code (s_width_code),
        .s_push_value (s_push_value),
        .cmd          (cmd),
        .stat         (stat),
        .m_pop_value  (m_pop_value),
        .m_pop_width  (m_pop_width),
        .m_status     (m_status)
    );

    // A request is never accepted in two consecutive cycles.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // Status is always a defined code.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == tmws_pkg::STAT_OK ||
                     m_status == tmws_pkg::STAT_OVERFLOW ||
                     m_status == tmws_pkg::STAT_UNDERFLOW))
        else $error("undefined status code");

    // Error results carry zero value and width (push results are zeroed as well).
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != tmws_pkg::STAT_OK) |->
            (m_pop_value == '0 && m_pop_width == tmws_pkg::WC_BYTE))
        else $error("error result carries data");

    // A popped byte value fits in its low byte.
    a_width_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pop_width == tmws_pkg::WC_BYTE) |-> (m_pop_value[31:8] == '0))
        else $error("byte result wider than a byte");

    // A result is only produced by the sequencer's load step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result valid without a result load");

endmodule

`default_nettype wire

@@ test/stack_checker.sv @@
// ----------------------------------------------------------------------------
// stack_checker
// Watches both channels of the tagged mixed-width stack, predicts every
// result from its own copy of the byte store and width tags, and counts errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stack_checker
    import tmws_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_opcode,
    input  logic [1:0]  s_width_code,
    input  logic [31:0] s_push_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_pop_value,
    input  logic [1:0]  m_pop_width,
    input  logic [1:0]  m_status,
    output int          error_count,
    output int          pending
);

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  width;
        logic [1:0]  status;
    } stack_result_t;

    // Shadow copy of the stack contents.
    logic [7:0]    byte_mem [STORE_BYTES];
    logic [1:0]    tag_mem  [MAX_ENTRIES];
    int            used_bytes;
    int            live_entries;
    stack_result_t due_results [$];

    initial begin
        error_count = 0;
        pending     = 0;
    end

    function automatic int entry_bytes(input logic [1:0] code);
        int n;
        case (code)
            WC_BYTE: n = 1;
            WC_WORD: n = 2;
            default: n = 4;
        endcase
        return n;
    endfunction

    // Applies one request to the shadow stack and returns the result it gives.
    function automatic stack_result_t stack_apply(input logic op, input logic [1:0] wc,
                                                  input logic [31:0] val);
        stack_result_t r;
        logic [1:0]    tag;
        int            n;
        int            base;
        int            i;
        r = '0;
        if (op == OP_PUSH) begin
            n = entry_bytes(wc);
            if (wc == WC_BAD || live_entries >= MAX_ENTRIES ||
                n > STORE_BYTES - used_bytes) begin
                r.status = STAT_OVERFLOW;
            end else begin
                for (i = 0; i < n; i++) begin
                    byte_mem[used_bytes + i] = val[8*i +: 8];
                end
                tag_mem[live_entries] = wc;
                used_bytes   = used_bytes + n;
                live_entries = live_entries + 1;
            end
        end else begin
            if (live_entries == 0) begin
                r.status = STAT_UNDERFLOW;
            end else begin
                tag = tag_mem[live_entries - 1];
                n   = entry_bytes(tag);
                if (n > used_bytes) begin
                    r.status = STAT_UNDERFLOW;
                end else begin
                    base = used_bytes - n;
                    for (i = 0; i < n; i++) begin
                        r.value[8*i +: 8] = byte_mem[base + i];
                    end
                    r.width      = tag;
                    used_bytes   = base;
                    live_entries = live_entries - 1;
                end
            end
        end
        return r;
    endfunction

    // Counts an error and reports only the first ten of them.
    task automatic report_error(input string why, input stack_result_t want,
                                input stack_result_t got);
        error_count = error_count + 1;
        if (error_count <= 10) begin
            $display("%0t: %s: expected value %08h width %0d status %0d,",
                     $time, why, want.value, want.width, want.status,
                     " got value %08h width %0d status %0d",
                     got.value, got.width, got.status);
        end
    endtask

    // Results are checked before the request of the same edge is predicted;
    // a request can never produce its result on the edge it is accepted.
    always @(posedge aclk) begin
        stack_result_t got;
        stack_result_t want;
        if (!aresetn) begin
            used_bytes   = 0;
            live_entries = 0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.value  = m_pop_value;
                got.width  = m_pop_width;
                got.status = m_status;
                if (due_results.size() == 0) begin
                    report_error("result with no request pending", '0, got);
                end else begin
                    want = due_results.pop_front();
                    if (got.value !== want.value || got.width !== want.width ||
                        got.status !== want.status) begin
                        report_error("result mismatch", want, got);
                    end
                end
            end
            if (s_valid && s_ready) begin
                due_results.push_back(stack_apply(s_opcode, s_width_code, s_push_value));
            end
        end
        pending = due_results.size();
    end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives push and pop requests into the tagged mixed-width stack with random
// gaps on both channels: a directed opening, then a fill to capacity, a
// drain past empty and a mixed stretch. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import tmws_pkg::*;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic        s_opcode     = OP_PUSH;
    logic [1:0]  s_width_code = WC_BYTE;
    logic [31:0] s_push_value = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [31:0] m_pop_value;
    logic [1:0]  m_pop_width;
    logic [1:0]  m_status;
    int          error_count;
    int          pending;
    bit          send_quiet   = 1'b0;

    always #10 aclk = ~aclk;

    tagged_mixed_width_stack u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_width_code(s_width_code),
        .s_push_value(s_push_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pop_value (m_pop_value),
        .m_pop_width (m_pop_width),
        .m_status    (m_status)
    );

    stack_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_width_code(s_width_code),
        .s_push_value(s_push_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pop_value (m_pop_value),
        .m_pop_width (m_pop_width),
        .m_status    (m_status),
        .error_count (error_count),
        .pending     (pending)
    );

    // Idle cycles before the next request or result; none in quiet stretches.
    function automatic int pick_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // Presents one request and holds it until the stack accepts it.
    task automatic send_request(input logic op, input logic [1:0] wc,
                                input logic [31:0] val);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            send_quiet = !send_quiet;
        end
        gap = pick_wait(send_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_width_code <= wc;
        s_push_value <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random request; pushes lean toward double words so the store fills.
    task automatic random_request(input int push_pct);
        logic       op;
        logic [1:0] wc;
        int         pick;
        op   = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            wc = WC_BAD;
        end else if (pick < 18) begin
            wc = WC_BYTE;
        end else if (pick < 32) begin
            wc = WC_WORD;
        end else begin
            wc = WC_DWORD;
        end
        send_request(op, wc, $urandom());
    endtask

    // Result side: random stalls on m_ready with quiet stretches.
    initial begin
        bit quiet;
        int stall;
        quiet = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                quiet = !quiet;
            end
            stall = pick_wait(quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Stimulus and verdict.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Pop on an empty stack, then a word as the very first push.
        send_request(OP_POP,  WC_BYTE,  32'h0000_0000);
        send_request(OP_PUSH, WC_WORD,  32'h0000_FFFF);
        send_request(OP_PUSH, WC_WORD,  32'hFFFF_0000);
        send_request(OP_PUSH, WC_BYTE,  32'h0000_00FF);
        send_request(OP_PUSH, WC_BYTE,  32'hFFFF_FF00);
        send_request(OP_PUSH, WC_DWORD, 32'hFFFF_FFFF);
        send_request(OP_PUSH, WC_DWORD, 32'h0000_0000);
        send_request(OP_PUSH, WC_DWORD, 32'hA5C3_0F96);
        // An invalid width code is rejected like an overflow.
        send_request(OP_PUSH, WC_BAD,   32'hFFFF_FFFF);
        repeat (7) send_request(OP_POP, WC_BAD, 32'hFFFF_FFFF);
        send_request(OP_POP,  WC_DWORD, 32'h1234_5678);
        send_request(OP_PUSH, WC_WORD,  32'h8765_1234);
        send_request(OP_PUSH, WC_BYTE,  32'h0000_0056);
        send_request(OP_POP,  WC_WORD,  32'h0000_0000);
        send_request(OP_POP,  WC_BYTE,  32'h0000_0000);

        // Fill past capacity, drain past empty, then mix.
        repeat (380) random_request(97);
        repeat (370) random_request(2);
        repeat (100) random_request(50);
        s_valid <= 1'b0;

        // One more edge so the checker has logged the last accepted request.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

endmodule
